// ===== hdl/drp_pkg.sv =====
// ----------------------------------------------------------------------------
// Reply frame parser package
// Shared types and constants for the display reply frame parser.
// ----------------------------------------------------------------------------
package drp_pkg;

   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 32;

   // Frame kinds and the terminator byte.
   localparam logic [BYTE_W-1:0] KIND_TOUCH  = 8'h65;
   localparam logic [BYTE_W-1:0] KIND_NUMBER = 8'h71;
   localparam logic [BYTE_W-1:0] TERM_BYTE   = 8'hFF;

   // Terminator count at which the next terminator closes the frame.
   localparam logic [1:0] TERM_LAST = 2'd2;

   typedef struct packed {
      logic [VALUE_W-1:0] reply_value;
      logic               reply_valid;
      logic [BYTE_W-1:0]  lead_byte;
      logic [BYTE_W-1:0]  second_byte;
      logic [BYTE_W-1:0]  third_byte;
      logic [BYTE_W-1:0]  fourth_byte;
   } drp_result_type;

   // One received byte handed from the input register to the parser.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] rx_byte;
   } drp_step_type;

endpackage

// ===== hdl/drp_in_reg.sv =====
// ----------------------------------------------------------------------------
// Input register
// Holds one received word until the parser takes it.
// ----------------------------------------------------------------------------
module drp_in_reg
   import drp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // rx_byte[7:0]
   input  logic              advance,
   output drp_step_type      held
);

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;

   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
      end
   end

   assign held.valid   = valid_ff;
   assign held.rx_byte = byte_ff;

endmodule

// ===== hdl/drp_parse.sv =====
// ----------------------------------------------------------------------------
// Frame parser core
// Frame store, write index, open flag and terminator count, updated once
// per word, with the result fields formed from the updated store.
// ----------------------------------------------------------------------------
module drp_parse
   import drp_pkg::*;
#(
   parameter int STORE_DEPTH = 8
)
(
   input  logic           clock,
   input  logic           reset,
   input  drp_step_type   step,
   output logic           done,
   output drp_result_type result
);

   localparam int IDX_W = $clog2(STORE_DEPTH + 1);
   localparam int POS_W = $clog2(STORE_DEPTH);

   logic [BYTE_W-1:0] store_ff [STORE_DEPTH];
   logic [BYTE_W-1:0] store_in [STORE_DEPTH];
   logic [IDX_W-1:0]  index_ff;
   logic [IDX_W-1:0]  index_in;
   logic              open_ff;
   logic              open_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              fits;
   logic              is_kind;
   logic              is_term;
   logic              valid;

   always_comb begin
      fits    = index_ff < IDX_W'(STORE_DEPTH);
      is_kind = (step.rx_byte == KIND_TOUCH) || (step.rx_byte == KIND_NUMBER);
      is_term = step.rx_byte == TERM_BYTE;

      for (int i = 0; i < STORE_DEPTH; i++) begin
         store_in[i] = store_ff[i];
         if (step.valid && fits && index_ff[POS_W-1:0] == POS_W'(i)) begin
            store_in[i] = step.rx_byte;
         end
      end

      done     = 1'b0;
      count_in = count_ff;
      open_in  = open_ff;
      index_in = index_ff;
      if (step.valid) begin
         if (is_kind) begin
            open_in = 1'b1;
         end
         if (is_term) begin
            if (count_ff == TERM_LAST) begin
               done     = 1'b1;
               count_in = 2'd0;
               open_in  = 1'b0;
               index_in = '0;
            end else begin
               count_in = count_ff + 2'd1;
            end
         end
         // A closed frame leaves the index at zero since the open flag dropped.
         if (open_in && fits) begin
            index_in = index_ff + IDX_W'(1);
         end
      end

      valid = (store_in[0] == KIND_NUMBER) && (store_in[5] == TERM_BYTE) &&
              (store_in[6] == TERM_BYTE) && (store_in[7] == TERM_BYTE);
      result.reply_valid = valid;
      result.reply_value = valid ? {store_in[4], store_in[3], store_in[2], store_in[1]}
                                 : '0;
      result.lead_byte   = store_in[0];
      result.second_byte = store_in[1];
      result.third_byte  = store_in[2];
      result.fourth_byte = store_in[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         open_ff  <= 1'b0;
         count_ff <= 2'd0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         index_ff <= index_in;
         open_ff  <= open_in;
         count_ff <= count_in;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

endmodule

// ===== hdl/drp_out_reg.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one finished result word until the receiver takes it.
// ----------------------------------------------------------------------------
module drp_out_reg
   import drp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  drp_result_type result,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [63:0]    rsp_tdata,   // reply_value[31:0], lead_byte, second_byte,
                                       // third_byte, fourth_byte
   output logic [0:0]     rsp_tuser    // reply_valid
);

   logic           valid_ff;
   logic           valid_in;
   drp_result_type result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {result_ff.fourth_byte, result_ff.third_byte,
                        result_ff.second_byte, result_ff.lead_byte,
                        result_ff.reply_value};
   assign rsp_tuser  = result_ff.reply_valid;

endmodule

// ===== hdl/display_reply_frame_parser.sv =====
// ----------------------------------------------------------------------------
// Display reply frame parser
// Collects bytes from the display's serial link into frames and reports
// each frame when its third terminator byte arrives.
// ----------------------------------------------------------------------------
// The req_ channel takes one received byte per word. A byte of 0x65 or 0x71
// opens a frame; every 0xFF byte counts as a terminator and the third one
// closes the frame and sends one word on the rsp_ channel. That word carries
// the first four stored bytes and, for a numeric reply ending in three 0xFF
// bytes, the 32-bit little-endian value in stored bytes 1 to 4 with
// rsp_tuser set. Other bytes produce no result word.
// A byte accepted into the input register is parsed as it advances out, and
// a closing byte's result word is loaded into the result register at that
// edge. One byte is taken per cycle through the single parse step between
// the two registers unless the receiver stalls; then the result register
// holds its word and the input register takes one more byte, after which
// req_tready stays low until the result word is taken. Reset empties both
// registers and clears the frame store, write index, open flag and count.
// ----------------------------------------------------------------------------
module display_reply_frame_parser
   import drp_pkg::*;
#(
   parameter int STORE_DEPTH = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // reply_value[31:0], lead_byte[39:32],
                                    // second_byte[47:40], third_byte[55:48],
                                    // fourth_byte[63:56]
   output logic [0:0]  rsp_tuser    // reply_valid
);

   drp_step_type   held;
   drp_step_type   step;
   drp_result_type result;
   logic           advance;
   logic           done;

   assign advance      = held.valid && (!rsp_tvalid || rsp_tready);
   assign step.valid   = advance;
   assign step.rx_byte = held.rx_byte;

   drp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .held       (held)
   );

   drp_parse #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .done   (done),
      .result (result)
   );

   drp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (done),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
